// ===== hdl/xetd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xetd_pkg
// shared types, constants and name tables of the xml entity text decoder
// ----------------------------------------------------------------------------
package xetd_pkg;

    localparam int PEND_DEPTH   = 16;
    localparam int CODE_LEN     = 8;
    localparam int NAME_MAX_LEN = 4;
    localparam int NUM_NAMES    = 6;
    localparam int PEND_AW      = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
    localparam int PEND_CW      = $clog2(PEND_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [NUM_NAMES-1:0] ALL_CANDIDATES = '1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_end;
    } t_out;

    typedef enum logic [1:0] {
        PH_SKIP = 2'd0,
        PH_COPY = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        OSEL_AMP  = 3'd0,
        OSEL_NAME = 3'd1,
        OSEL_PROD = 3'd2,
        OSEL_PEND = 3'd3,
        OSEL_END  = 3'd4
    } t_osel;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_DISPATCH  = 4'd1,
        ST_PLAIN     = 4'd2,
        ST_PROD      = 4'd3,
        ST_EMIT_PROD = 4'd4,
        ST_FL_RD     = 4'd5,
        ST_FL_WR     = 4'd6,
        ST_OVF_RD    = 4'd7,
        ST_OVF_WR    = 4'd8,
        ST_PUSH      = 4'd9,
        ST_LAST      = 4'd10,
        ST_END       = 4'd11,
        ST_UNM_AMP   = 4'd12,
        ST_UNM_NAME  = 4'd13
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic   latch_in;
        logic   out_load;
        t_osel  out_sel;
        logic   ram_rd;
        logic   pop;
        logic   push;
        logic   pend_clear;
        logic   ent_start;
        logic   ent_extend;
        logic   ent_clear;
        logic   idx_clr;
        logic   idx_inc;
        logic   prod_from_ent;
        logic   prod_from_byte;
        logic   phase_wr;
        t_phase phase_val;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
        logic byte_end;
        logic byte_ws;
        logic byte_amp;
        logic phase_skip;
        logic phase_done;
        logic ent_active;
        logic ent_match;
        logic ent_extend;
        logic len_zero;
        logic name_last;
        logic prod_ws;
        logic pend_empty;
        logic pend_one;
        logic pend_full;
        logic out_free;
    } t_stat;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        return ((b >= CH_LOW_A) && (b <= CH_LOW_Z)) ? b - CASE_OFS : b;
    endfunction

    // names in order: lt, gt, amp, apos, quot, nbsp
    function automatic logic [7:0] name_char(input logic [2:0] k, input logic [1:0] pos);
        logic [7:0] c;
        c = CH_NUL;
        case ({k, pos})
            {3'd0, 2'd0}: c = "L";
            {3'd0, 2'd1}: c = "T";
            {3'd1, 2'd0}: c = "G";
            {3'd1, 2'd1}: c = "T";
            {3'd2, 2'd0}: c = "A";
            {3'd2, 2'd1}: c = "M";
            {3'd2, 2'd2}: c = "P";
            {3'd3, 2'd0}: c = "A";
            {3'd3, 2'd1}: c = "P";
            {3'd3, 2'd2}: c = "O";
            {3'd3, 2'd3}: c = "S";
            {3'd4, 2'd0}: c = "Q";
            {3'd4, 2'd1}: c = "U";
            {3'd4, 2'd2}: c = "O";
            {3'd4, 2'd3}: c = "T";
            {3'd5, 2'd0}: c = "N";
            {3'd5, 2'd1}: c = "B";
            {3'd5, 2'd2}: c = "S";
            {3'd5, 2'd3}: c = "P";
            default:      c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] name_len(input logic [2:0] k);
        logic [2:0] n;
        case (k)
            3'd0:    n = 3'd2;
            3'd1:    n = 3'd2;
            3'd2:    n = 3'd3;
            3'd3:    n = 3'd4;
            3'd4:    n = 3'd4;
            3'd5:    n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] name_value(input logic [2:0] k);
        logic [7:0] v;
        case (k)
            3'd0:    v = "<";
            3'd1:    v = ">";
            3'd2:    v = "&";
            3'd3:    v = 8'h27;
            3'd4:    v = 8'h22;
            3'd5:    v = CH_SPACE;
            default: v = CH_NUL;
        endcase
        return v;
    endfunction

    function automatic logic [PEND_AW-1:0] ptr_inc(input logic [PEND_AW-1:0] p);
        return (p == PEND_AW'(PEND_DEPTH - 1)) ? '0 : p + PEND_AW'(1);
    endfunction

endpackage

// ===== hdl/xetd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xetd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module xetd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/xetd_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xetd_dp
// datapath: input latch, entity matcher, held whitespace queue, output register
// ----------------------------------------------------------------------------
module xetd_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  xetd_pkg::t_in      i_in_data,
    input  xetd_pkg::t_cmd     i_cmd,
    output xetd_pkg::t_stat    o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output xetd_pkg::t_out     o_out_data
);

    logic [7:0]                       r_byte;
    logic                             r_last;
    xetd_pkg::t_phase                 r_phase;
    logic                             r_active;
    logic [2:0]                       r_len;
    logic [xetd_pkg::NUM_NAMES-1:0]   r_mask;
    logic [7:0]                       r_prefix [xetd_pkg::NAME_MAX_LEN];
    logic [1:0]                       r_idx;
    logic [7:0]                       r_prod;
    logic [xetd_pkg::PEND_AW-1:0]     r_head;
    logic [xetd_pkg::PEND_AW-1:0]     r_tail;
    logic [xetd_pkg::PEND_CW-1:0]     r_count;
    logic                             r_out_valid;
    xetd_pkg::t_out                   r_out;

    logic [7:0]                       w_upper;
    logic [xetd_pkg::NUM_NAMES-1:0]   w_next;
    logic                             w_match;
    logic [7:0]                       w_value;
    logic [7:0]                       w_rdata;
    logic                             w_out_free;

    // entity matcher: narrow the candidates, or look for a complete name at ';'
    always_comb begin
        w_upper = xetd_pkg::to_upper(r_byte);
        w_next  = '0;
        w_match = 1'b0;
        w_value = xetd_pkg::CH_NUL;
        for (int k = xetd_pkg::NUM_NAMES - 1; k >= 0; k--) begin
            if (r_mask[k] && (r_len < xetd_pkg::name_len(3'(k)))
                && (xetd_pkg::name_char(3'(k), r_len[1:0]) == w_upper)) begin
                w_next[k] = 1'b1;
            end
            if (r_mask[k] && (xetd_pkg::name_len(3'(k)) == r_len)
                && ((4'(r_len) + 4'd1) <= 4'(xetd_pkg::CODE_LEN))) begin
                w_match = 1'b1;
                w_value = xetd_pkg::name_value(3'(k));
            end
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat            = '0;
        o_stat.last       = r_last;
        o_stat.byte_end   = (r_byte == xetd_pkg::CH_NUL) || (r_byte == xetd_pkg::CH_LT);
        o_stat.byte_ws    = xetd_pkg::is_ws(r_byte);
        o_stat.byte_amp   = (r_byte == xetd_pkg::CH_AMP);
        o_stat.phase_skip = (r_phase == xetd_pkg::PH_SKIP);
        o_stat.phase_done = (r_phase == xetd_pkg::PH_DONE);
        o_stat.ent_active = r_active;
        o_stat.ent_match  = (w_upper == xetd_pkg::CH_SEMI) && w_match;
        o_stat.ent_extend = (w_upper != xetd_pkg::CH_SEMI)
                            && (r_len < 3'(xetd_pkg::NAME_MAX_LEN)) && (w_next != '0);
        o_stat.len_zero   = (r_len == 3'd0);
        o_stat.name_last  = ((3'(r_idx) + 3'd1) == r_len);
        o_stat.prod_ws    = xetd_pkg::is_ws(r_prod);
        o_stat.pend_empty = (r_count == '0);
        o_stat.pend_one   = (r_count == xetd_pkg::PEND_CW'(1));
        o_stat.pend_full  = (r_count == xetd_pkg::PEND_CW'(xetd_pkg::PEND_DEPTH));
        o_stat.out_free   = w_out_free;
    end

    xetd_ram #(
        .WIDTH (8),
        .DEPTH (xetd_pkg::PEND_DEPTH)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_tail),
        .i_wdata (r_prod),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_byte <= i_in_data.in_byte;
            r_last <= i_in_data.in_last;
        end
        if (i_cmd.ent_extend) begin
            r_prefix[r_len[1:0]] <= r_byte;
        end
        if (i_cmd.prod_from_ent) begin
            r_prod <= w_value;
        end else if (i_cmd.prod_from_byte) begin
            r_prod <= r_byte;
        end
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                xetd_pkg::OSEL_AMP:  r_out <= '{out_byte: xetd_pkg::CH_AMP, out_end: 1'b0};
                xetd_pkg::OSEL_NAME: r_out <= '{out_byte: r_prefix[r_idx], out_end: 1'b0};
                xetd_pkg::OSEL_PROD: r_out <= '{out_byte: r_prod, out_end: 1'b0};
                xetd_pkg::OSEL_PEND: r_out <= '{out_byte: w_rdata, out_end: 1'b0};
                xetd_pkg::OSEL_END:  r_out <= '{out_byte: xetd_pkg::CH_NUL, out_end: 1'b1};
                default:             r_out <= '{out_byte: xetd_pkg::CH_NUL, out_end: 1'b1};
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= xetd_pkg::PH_SKIP;
            r_active    <= 1'b0;
            r_len       <= '0;
            r_mask      <= xetd_pkg::ALL_CANDIDATES;
            r_idx       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.phase_wr) begin
                r_phase <= i_cmd.phase_val;
            end

            if (i_cmd.ent_start || i_cmd.ent_clear) begin
                r_active <= i_cmd.ent_start;
                r_len    <= '0;
                r_mask   <= xetd_pkg::ALL_CANDIDATES;
            end else if (i_cmd.ent_extend) begin
                r_len  <= r_len + 3'd1;
                r_mask <= w_next;
            end

            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 2'd1;
            end

            if (i_cmd.pend_clear) begin
                r_count <= '0;
                r_head  <= r_tail;
            end else if (i_cmd.pop) begin
                r_count <= r_count - xetd_pkg::PEND_CW'(1);
                r_head  <= xetd_pkg::ptr_inc(r_head);
            end else if (i_cmd.push) begin
                r_count <= r_count + xetd_pkg::PEND_CW'(1);
                r_tail  <= xetd_pkg::ptr_inc(r_tail);
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/xetd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xetd_ctrl
// controller: walks one input byte through matching, flushing and emitting
// ----------------------------------------------------------------------------
module xetd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  xetd_pkg::t_stat i_stat,
    output xetd_pkg::t_cmd  o_cmd
);

    xetd_pkg::t_state r_state, n_state;
    xetd_pkg::t_state r_fl_ret, n_fl_ret;
    xetd_pkg::t_state r_unm_ret, n_unm_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= xetd_pkg::ST_IDLE;
            r_fl_ret  <= xetd_pkg::ST_IDLE;
            r_unm_ret <= xetd_pkg::ST_IDLE;
        end else begin
            r_state   <= n_state;
            r_fl_ret  <= n_fl_ret;
            r_unm_ret <= n_unm_ret;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_fl_ret   = r_fl_ret;
        n_unm_ret  = r_unm_ret;
        o_cmd      = '0;
        o_in_ready = 1'b0;

        case (r_state)
            xetd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = xetd_pkg::ST_DISPATCH;
                end
            end

            xetd_pkg::ST_DISPATCH: begin
                if (i_stat.phase_done) begin
                    n_state = xetd_pkg::ST_LAST;
                end else if (!i_stat.ent_active) begin
                    n_state = xetd_pkg::ST_PLAIN;
                end else if (i_stat.ent_match) begin
                    o_cmd.ent_clear     = 1'b1;
                    o_cmd.prod_from_ent = 1'b1;
                    n_state             = xetd_pkg::ST_PROD;
                end else if (i_stat.ent_extend) begin
                    o_cmd.ent_extend = 1'b1;
                    n_state          = xetd_pkg::ST_LAST;
                end else begin
                    // broken match: spill '&' and the name, then redo the byte
                    n_unm_ret = xetd_pkg::ST_PLAIN;
                    if (i_stat.pend_empty) begin
                        n_state = xetd_pkg::ST_UNM_AMP;
                    end else begin
                        n_fl_ret = xetd_pkg::ST_UNM_AMP;
                        n_state  = xetd_pkg::ST_FL_RD;
                    end
                end
            end

            xetd_pkg::ST_PLAIN: begin
                if (i_stat.byte_end) begin
                    o_cmd.phase_wr  = 1'b1;
                    o_cmd.phase_val = xetd_pkg::PH_DONE;
                    n_state         = xetd_pkg::ST_LAST;
                end else if (i_stat.phase_skip && i_stat.byte_ws) begin
                    n_state = xetd_pkg::ST_LAST;
                end else begin
                    o_cmd.phase_wr  = 1'b1;
                    o_cmd.phase_val = xetd_pkg::PH_COPY;
                    if (i_stat.byte_amp) begin
                        o_cmd.ent_start = 1'b1;
                        n_state         = xetd_pkg::ST_LAST;
                    end else begin
                        o_cmd.prod_from_byte = 1'b1;
                        n_state              = xetd_pkg::ST_PROD;
                    end
                end
            end

            xetd_pkg::ST_PROD: begin
                if (i_stat.prod_ws) begin
                    n_state = i_stat.pend_full ? xetd_pkg::ST_OVF_RD : xetd_pkg::ST_PUSH;
                end else if (i_stat.pend_empty) begin
                    n_state = xetd_pkg::ST_EMIT_PROD;
                end else begin
                    n_fl_ret = xetd_pkg::ST_EMIT_PROD;
                    n_state  = xetd_pkg::ST_FL_RD;
                end
            end

            xetd_pkg::ST_EMIT_PROD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = xetd_pkg::OSEL_PROD;
                    n_state        = xetd_pkg::ST_LAST;
                end
            end

            xetd_pkg::ST_FL_RD: begin
                o_cmd.ram_rd = 1'b1;
                n_state      = xetd_pkg::ST_FL_WR;
            end

            xetd_pkg::ST_FL_WR: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = xetd_pkg::OSEL_PEND;
                    o_cmd.pop      = 1'b1;
                    n_state        = i_stat.pend_one ? r_fl_ret : xetd_pkg::ST_FL_RD;
                end
            end

            xetd_pkg::ST_OVF_RD: begin
                o_cmd.ram_rd = 1'b1;
                n_state      = xetd_pkg::ST_OVF_WR;
            end

            xetd_pkg::ST_OVF_WR: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = xetd_pkg::OSEL_PEND;
                    o_cmd.pop      = 1'b1;
                    n_state        = xetd_pkg::ST_PUSH;
                end
            end

            xetd_pkg::ST_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = xetd_pkg::ST_LAST;
            end

            xetd_pkg::ST_LAST: begin
                if (!i_stat.last) begin
                    n_state = xetd_pkg::ST_IDLE;
                end else if (i_stat.ent_active) begin
                    n_unm_ret = xetd_pkg::ST_END;
                    if (i_stat.pend_empty) begin
                        n_state = xetd_pkg::ST_UNM_AMP;
                    end else begin
                        n_fl_ret = xetd_pkg::ST_UNM_AMP;
                        n_state  = xetd_pkg::ST_FL_RD;
                    end
                end else begin
                    n_state = xetd_pkg::ST_END;
                end
            end

            xetd_pkg::ST_END: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_sel    = xetd_pkg::OSEL_END;
                    o_cmd.pend_clear = 1'b1;
                    o_cmd.ent_clear  = 1'b1;
                    o_cmd.phase_wr   = 1'b1;
                    o_cmd.phase_val  = xetd_pkg::PH_SKIP;
                    n_state          = xetd_pkg::ST_IDLE;
                end
            end

            xetd_pkg::ST_UNM_AMP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = xetd_pkg::OSEL_AMP;
                    o_cmd.idx_clr  = 1'b1;
                    if (i_stat.len_zero) begin
                        o_cmd.ent_clear = 1'b1;
                        n_state         = r_unm_ret;
                    end else begin
                        n_state = xetd_pkg::ST_UNM_NAME;
                    end
                end
            end

            xetd_pkg::ST_UNM_NAME: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = xetd_pkg::OSEL_NAME;
                    o_cmd.idx_inc  = 1'b1;
                    if (i_stat.name_last) begin
                        o_cmd.ent_clear = 1'b1;
                        n_state         = r_unm_ret;
                    end
                end
            end

            default: begin
                n_state = xetd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/xml_entity_text_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_text_decoder
// decodes the bytes of one xml text value, one byte per transfer
// ----------------------------------------------------------------------------
// The block takes one byte per transfer and works on it alone; o_in_ready is
// high only while the controller waits in its idle state. A byte that is simply
// copied goes through latch, dispatch, classify, produce, emit and last check
// before the next input transfer. A held whitespace byte that must go out is
// first read from the holding queue, a ram with a registered read port. An
// unmatched entity spills '&' plus up to four name bytes, and the final byte
// of a string is followed by the end transfer. A stalled output holds the
// controller until the output register is free. Leading whitespace is dropped,
// text ends at '<' or a zero byte, lt/gt/amp/apos/quot/nbsp are decoded
// case-insensitively, and trailing whitespace held in the queue is dropped at
// the end of the string; a whitespace byte that finds the queue full sends
// the oldest held byte on first.
// ----------------------------------------------------------------------------
module xml_entity_text_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  xetd_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output xetd_pkg::t_out o_out_data
);

    // command and status between the controller and the datapath
    xetd_pkg::t_cmd  w_cmd;
    xetd_pkg::t_stat w_stat;

    // sequencer: one state per micro step of the current byte
    xetd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // matcher, whitespace queue and output register
    xetd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hdl/xetd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xetd_checker
// port-level checks of the xml entity text decoder
// ----------------------------------------------------------------------------
module xetd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input xetd_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input xetd_pkg::t_out o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // only the end transfer carries a zero byte
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.out_byte == 8'h00) == o_out_data.out_end))
        else $error("end flag and zero byte disagree");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // one byte at a time: no input transfer in the cycle after one
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken in back to back cycles");

endmodule

bind xml_entity_text_decoder xetd_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
